// File: rtl/core/ftod_pkg.sv
`timescale 1ns / 1ps

package ftod_pkg;

    localparam int RATE_W     = 26;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int SKIP_W     = 3;
    localparam int LFSR_W     = 16;
    localparam int DIVISOR_W  = BYTE_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;

    localparam int INDEX_WINDOW_BITS_DEF = 2048;

    localparam logic [RATE_W-1:0] NOMINAL_BITRATE_RST = RATE_W'(250000);
    localparam logic [RATE_W-1:0] EMULATOR_CLOCK_RST  = RATE_W'(36000000);
    localparam logic [LFSR_W-1:0] LFSR_SEED           = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS           = 16'hB400;
    localparam logic [BYTE_W-1:0] RAND_MASK           = 8'h54;
    localparam logic [BYTE_W-1:0] FULL_BYTE           = 8'hFF;
    localparam logic [3:0]        OPC_NIBBLE          = 4'hF;

    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_BITRATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EMULATOR_CLOCK  = 1'b1;

    localparam logic [BYTE_W-1:0] OPC_NOP        = 8'hF0;
    localparam logic [BYTE_W-1:0] OPC_SETINDEX   = 8'hF1;
    localparam logic [BYTE_W-1:0] OPC_SETBITRATE = 8'hF2;
    localparam logic [BYTE_W-1:0] OPC_SKIPBITS   = 8'hF3;
    localparam logic [BYTE_W-1:0] OPC_RAND       = 8'hF4;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_RATE,
        PEND_SKIP
    } ftod_pend_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } ftod_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ftod_cmd_t;

    typedef struct packed {
        logic emits;
        logic starts_div;
        logic out_busy;
        logic div_done;
    } ftod_stat_t;

    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/floppy_track_opcode_decoder_top.sv
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                              tuser
// s_        in   track_byte[7:0]                                 side_start
// m_        out  cell_bits[7:0] bit_count[11:8] index_mask[19:12]
//                bit_rate[45:20] rate_fault[46] pad[47]           flaky
// cfg_      in   write port, index 0 nominal_bitrate, 1 emulator_clock
//
// Flow: an item is taken in idle and decoded in the exec state; no new item is
//   taken until it is through. A nonzero rate operand also runs the 26-step
//   restoring divider, and the next item waits for its quotient.
// Reset: synchronous, active low.
// Stalls: one result waits in the output register while the next item is
//   taken; a result-producing item holds in decode until that register frees.

module floppy_track_opcode_decoder_top #(
    parameter int INDEX_WINDOW_BITS = ftod_pkg::INDEX_WINDOW_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [ftod_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ftod_pkg::RATE_W-1:0]    cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ftod_pkg::S_TDATA_W-1:0] s_tdata,   // track_byte
    input  logic                           s_tuser,   // side_start
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ftod_pkg::M_TDATA_W-1:0] m_tdata,   // cell_bits, bit_count,
                                                      // index_mask, bit_rate,
                                                      // rate_fault
    output logic                           m_tuser    // flaky
);
    import ftod_pkg::*;

    ftod_cmd_t  cmd;
    ftod_stat_t stat;

    // sequencer: idle / decode / wait on divider
    ftod_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // decode state, divider and output register
    ftod_datapath #(
        .INDEX_WINDOW_BITS (INDEX_WINDOW_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: rtl/core/ftod_div.sv
`timescale 1ns / 1ps

module ftod_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ftod_pkg::RATE_W-1:0]    dividend,
    input  logic [ftod_pkg::DIVISOR_W-1:0] divisor,
    output logic                           done,
    output logic [ftod_pkg::RATE_W-1:0]    quotient
);
    import ftod_pkg::*;

    localparam int CNT_W = $clog2(RATE_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RATE_W-1:0]    quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W:0]   rem_sh, rem_sub;
    logic                 ge;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        rem_sh    = {rem_reg, quo_reg[RATE_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[RATE_W-2:0], ge};
            rem_next = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RATE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/ftod_datapath.sv
`timescale 1ns / 1ps

module ftod_datapath #(
    parameter int INDEX_WINDOW_BITS = ftod_pkg::INDEX_WINDOW_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ftod_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ftod_pkg::RATE_W-1:0]    cfg_wdata,
    input  logic [ftod_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  ftod_pkg::ftod_cmd_t            cmd,
    output ftod_pkg::ftod_stat_t           stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ftod_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import ftod_pkg::*;

    localparam int IDX_W = $clog2(INDEX_WINDOW_BITS + 1);
    localparam int CMP_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

    logic [RATE_W-1:0] nominal_reg, emu_clk_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              side_reg;

    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    ftod_pend_t        pend_reg, pend_next;
    logic [IDX_W-1:0]  il_reg, il_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic              fault_reg, fault_next;

    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  o_cells_reg, o_cells_next;
    logic [COUNT_W-1:0] o_count_reg, o_count_next;
    logic               o_flaky_reg, o_flaky_next;
    logic [BYTE_W-1:0]  o_mask_reg, o_mask_next;
    logic [RATE_W-1:0]  o_rate_reg, o_rate_next;
    logic               o_fault_reg, o_fault_next;

    // side-start view of the state
    logic [RATE_W-1:0]  rate_eff;
    logic [SKIP_W-1:0]  skip_eff;
    ftod_pend_t         pend_eff;
    logic [IDX_W-1:0]   il_eff;
    logic               fault_eff;

    logic [BYTE_W-1:0]  b;
    logic               is_op, emits;
    logic [LFSR_W-1:0]  lfsr_step;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  mask;
    logic [CMP_W-1:0]   il_w, cnt_w;
    logic [IDX_W-1:0]   il_after;
    logic [BYTE_W-1:0]  data_bits, rand_bits;

    logic              div_done;
    logic [RATE_W-1:0] quotient;

    ftod_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.exec && stat.starts_div),
        .dividend (emu_clk_reg),
        .divisor  ({b, 1'b0}),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_reg <= NOMINAL_BITRATE_RST;
            emu_clk_reg <= EMULATOR_CLOCK_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NOMINAL_BITRATE: nominal_reg <= cfg_wdata;
                REG_EMULATOR_CLOCK:  emu_clk_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= s_tdata[BYTE_W-1:0];
            side_reg <= s_tuser;
        end
    end

    always_comb begin
        rate_eff  = side_reg ? nominal_reg : rate_reg;
        skip_eff  = side_reg ? '0 : skip_reg;
        pend_eff  = side_reg ? PEND_NONE : pend_reg;
        il_eff    = side_reg ? '0 : il_reg;
        fault_eff = side_reg ? 1'b0 : fault_reg;

        b     = rev8(byte_reg);
        is_op = b[7:4] == OPC_NIBBLE;
        emits = (pend_eff == PEND_NONE) && (!is_op || b == OPC_RAND);

        lfsr_step = {1'b0, lfsr_reg[LFSR_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        count     = COUNT_W'(BYTE_W) - COUNT_W'(skip_eff);
        data_bits = b & (FULL_BYTE >> skip_eff);
        rand_bits = (lfsr_step[BYTE_W-1:0] & RAND_MASK) >> skip_eff;

        // bit j (from the right) is the (count-j)-th emitted bit
        il_w = CMP_W'(il_eff);
        cnt_w = CMP_W'(count);
        for (int j = 0; j < BYTE_W; j++) begin
            mask[j] = (COUNT_W'(j) < count) &&
                      (CMP_W'(count - COUNT_W'(j)) <= il_w);
        end
        il_after = (il_w > cnt_w) ? IDX_W'(il_w - cnt_w) : '0;
    end

    always_comb begin
        rate_next    = rate_reg;
        skip_next    = skip_reg;
        pend_next    = pend_reg;
        il_next      = il_reg;
        lfsr_next    = lfsr_reg;
        fault_next   = fault_reg;
        m_valid_next = m_valid_reg && !m_tready;
        o_cells_next = o_cells_reg;
        o_count_next = o_count_reg;
        o_flaky_next = o_flaky_reg;
        o_mask_next  = o_mask_reg;
        o_rate_next  = o_rate_reg;
        o_fault_next = o_fault_reg;

        if (div_done) begin
            rate_next = quotient;
        end else if (cmd.exec) begin
            rate_next  = rate_eff;
            skip_next  = skip_eff;
            pend_next  = PEND_NONE;
            il_next    = il_eff;
            fault_next = fault_eff;
            unique case (pend_eff)
                PEND_RATE: begin
                    if (b == '0) begin
                        fault_next = 1'b1;
                    end
                end
                PEND_SKIP: skip_next = b[SKIP_W-1:0];
                default: begin
                    if (is_op) begin
                        unique case (b)
                            OPC_SETINDEX:   il_next = IDX_W'(INDEX_WINDOW_BITS);
                            OPC_SETBITRATE: pend_next = PEND_RATE;
                            OPC_SKIPBITS:   pend_next = PEND_SKIP;
                            OPC_RAND:       lfsr_next = lfsr_step;
                            default: ;
                        endcase
                    end
                end
            endcase
            if (emits) begin
                skip_next    = '0;
                il_next      = il_after;
                m_valid_next = 1'b1;
                o_cells_next = is_op ? rand_bits : data_bits;
                o_count_next = count;
                o_flaky_next = is_op;
                o_mask_next  = mask;
                o_rate_next  = rate_eff;
                o_fault_next = fault_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg    <= NOMINAL_BITRATE_RST;
            skip_reg    <= '0;
            pend_reg    <= PEND_NONE;
            il_reg      <= '0;
            lfsr_reg    <= LFSR_SEED;
            fault_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rate_reg    <= rate_next;
            skip_reg    <= skip_next;
            pend_reg    <= pend_next;
            il_reg      <= il_next;
            lfsr_reg    <= lfsr_next;
            fault_reg   <= fault_next;
            m_valid_reg <= m_valid_next;
        end
        o_cells_reg <= o_cells_next;
        o_count_reg <= o_count_next;
        o_flaky_reg <= o_flaky_next;
        o_mask_reg  <= o_mask_next;
        o_rate_reg  <= o_rate_next;
        o_fault_reg <= o_fault_next;
    end

    assign stat.emits      = emits;
    assign stat.starts_div = (pend_eff == PEND_RATE) && (b != '0);
    assign stat.out_busy   = m_valid_reg && !m_tready;
    assign stat.div_done   = div_done;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_flaky_reg;
    assign m_tdata  = {1'b0, o_fault_reg, o_rate_reg, o_mask_reg, o_count_reg, o_cells_reg};

`ifndef SYNTHESIS
    a_no_emit_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && emits |-> !(m_valid_reg && !m_tready))
        else $error("result written over a waiting item");
    a_no_exec_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && stat.starts_div |=> !cmd.exec && !cmd.load)
        else $error("new item handled while divide runs");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (o_count_reg >= COUNT_W'(1)) && (o_count_reg <= COUNT_W'(BYTE_W)))
        else $error("bit count out of range");
    a_mask_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($countones(o_mask_reg) <= int'(o_count_reg)))
        else $error("index mask wider than bit count");
`endif

endmodule

// File: rtl/core/ftod_ctrl.sv
`timescale 1ns / 1ps

module ftod_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ftod_pkg::ftod_stat_t stat,
    output ftod_pkg::ftod_cmd_t  cmd
);
    import ftod_pkg::*;

    ftod_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the output register can take a result
                if (!(stat.emits && stat.out_busy)) begin
                    cmd.exec   = 1'b1;
                    state_next = stat.starts_div ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
